/* design/tsb_pkg.sv */
// Shared types, constants and helper functions for the texture sampler.
package tsb_pkg;

    localparam int MAX_DIM   = 256;
    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = 9;
    localparam int IDX_W     = 8;
    localparam int ADDR_W    = 16;
    localparam int COORD_W   = FRAC_BITS + 1;
    localparam int POS_W     = COORD_W + IDX_W;
    localparam int TEXEL_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int CHANS     = 4;
    localparam int HORZ_W    = CHAN_W + FRAC_BITS + 1;
    localparam int ACC_W     = HORZ_W + COORD_W;

    localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_BITS;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_TEX_WIDTH  = 1'b0;
    localparam logic REG_TEX_HEIGHT = 1'b1;

    // Input item.
    typedef struct packed {
        logic                opcode;
        logic [ADDR_W-1:0]   texel_index;
        logic [CHAN_W-1:0]   in_red;
        logic [CHAN_W-1:0]   in_green;
        logic [CHAN_W-1:0]   in_blue;
        logic [CHAN_W-1:0]   in_alpha;
        logic [COORD_W-1:0]  coord_u;
        logic [COORD_W-1:0]  coord_v;
        logic                use_nearest;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } out_t;

    // Request from the address stages to the texel store.
    typedef struct packed {
        logic                 valid;
        logic                 opcode;
        logic [ADDR_W-1:0]    waddr;
        logic [TEXEL_W-1:0]   wdata;
        logic [ADDR_W-1:0]    a00;
        logic [ADDR_W-1:0]    a10;
        logic [ADDR_W-1:0]    a01;
        logic [ADDR_W-1:0]    a11;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } mem_req_t;

    // Fetched texels handed to the filter stages.
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [TEXEL_W-1:0]   t00;
        logic [TEXEL_W-1:0]   t10;
        logic [TEXEL_W-1:0]   t01;
        logic [TEXEL_W-1:0]   t11;
    } filt_req_t;

    // A dimension of zero acts as one, and one above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // Clamp a texel index to the last texel of a dimension.
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [DIM_W:0] i,
                                                   input logic [DIM_W-1:0] dim);
        logic [DIM_W:0] lim;
        lim = {1'b0, dim} - (DIM_W+1)'(1);
        return (i > lim) ? lim[IDX_W-1:0] : i[IDX_W-1:0];
    endfunction

endpackage

/* design/tsb_addr.sv */
// Coordinate scaling, index clamping and texel address stages.
module tsb_addr (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  tsb_pkg::in_t            in_data,
    input  logic [tsb_pkg::DIM_W-1:0] tex_width,
    input  logic [tsb_pkg::DIM_W-1:0] tex_height,
    output tsb_pkg::mem_req_t       req
);

    logic [tsb_pkg::DIM_W-1:0] w_eff;
    logic [tsb_pkg::DIM_W-1:0] h_eff;

    // Stage 1: input register.
    logic         v1_reg;
    tsb_pkg::in_t item1_reg;

    // Stage 2: scaled positions.
    logic                        v2_reg;
    logic                        op2_reg;
    logic                        near2_reg;
    logic [tsb_pkg::ADDR_W-1:0]  idx2_reg;
    logic [tsb_pkg::TEXEL_W-1:0] tex2_reg;
    logic [tsb_pkg::POS_W-1:0]   px2_reg;
    logic [tsb_pkg::POS_W-1:0]   py2_reg;
    logic [tsb_pkg::POS_W-1:0]   px_next;
    logic [tsb_pkg::POS_W-1:0]   py_next;

    // Stage 3: clamped texel coordinates and fractions.
    logic                          v3_reg;
    logic                          op3_reg;
    logic [tsb_pkg::ADDR_W-1:0]    idx3_reg;
    logic [tsb_pkg::TEXEL_W-1:0]   tex3_reg;
    logic [tsb_pkg::IDX_W-1:0]     x0_reg, x1_reg, y0_reg, y1_reg;
    logic [tsb_pkg::FRAC_BITS-1:0] fx3_reg, fy3_reg;
    logic [tsb_pkg::IDX_W-1:0]     x0_next, x1_next, y0_next, y1_next;
    logic [tsb_pkg::FRAC_BITS-1:0] fx_next, fy_next;
    logic [tsb_pkg::POS_W:0]       pxr, pyr;
    logic [tsb_pkg::DIM_W:0]       xi, yi;

    // Stage 4: linear addresses.
    tsb_pkg::mem_req_t req_reg;
    tsb_pkg::mem_req_t req_next;

    assign w_eff = tsb_pkg::eff_dim(tex_width);
    assign h_eff = tsb_pkg::eff_dim(tex_height);

    // Scale the coordinates by the last texel index.
    always_comb
    begin
        px_next = tsb_pkg::POS_W'(item1_reg.coord_u
                  * tsb_pkg::IDX_W'(w_eff - tsb_pkg::DIM_W'(1)));
        py_next = tsb_pkg::POS_W'(item1_reg.coord_v
                  * tsb_pkg::IDX_W'(h_eff - tsb_pkg::DIM_W'(1)));
    end

    // Nearest picks one rounded texel with zero fractions; bilinear takes floor and floor+1.
    always_comb
    begin
        pxr = {1'b0, px2_reg} + (tsb_pkg::POS_W+1)'(1 << (tsb_pkg::FRAC_BITS - 1));
        pyr = {1'b0, py2_reg} + (tsb_pkg::POS_W+1)'(1 << (tsb_pkg::FRAC_BITS - 1));
        xi  = {1'b0, px2_reg[tsb_pkg::POS_W-1:tsb_pkg::FRAC_BITS]};
        yi  = {1'b0, py2_reg[tsb_pkg::POS_W-1:tsb_pkg::FRAC_BITS]};
        if (near2_reg)
        begin
            x0_next = tsb_pkg::clamp_idx(pxr[tsb_pkg::POS_W:tsb_pkg::FRAC_BITS], w_eff);
            y0_next = tsb_pkg::clamp_idx(pyr[tsb_pkg::POS_W:tsb_pkg::FRAC_BITS], h_eff);
            x1_next = x0_next;
            y1_next = y0_next;
            fx_next = '0;
            fy_next = '0;
        end
        else
        begin
            x0_next = tsb_pkg::clamp_idx(xi, w_eff);
            y0_next = tsb_pkg::clamp_idx(yi, h_eff);
            x1_next = tsb_pkg::clamp_idx(xi + (tsb_pkg::DIM_W+1)'(1), w_eff);
            y1_next = tsb_pkg::clamp_idx(yi + (tsb_pkg::DIM_W+1)'(1), h_eff);
            fx_next = px2_reg[tsb_pkg::FRAC_BITS-1:0];
            fy_next = py2_reg[tsb_pkg::FRAC_BITS-1:0];
        end
    end

    // Linear addresses y*width+x, modulo the store depth.
    always_comb
    begin
        req_next.valid  = v3_reg;
        req_next.opcode = op3_reg;
        req_next.waddr  = idx3_reg;
        req_next.wdata  = tex3_reg;
        req_next.a00    = tsb_pkg::ADDR_W'(y0_reg * w_eff + x0_reg);
        req_next.a10    = tsb_pkg::ADDR_W'(y0_reg * w_eff + x1_reg);
        req_next.a01    = tsb_pkg::ADDR_W'(y1_reg * w_eff + x0_reg);
        req_next.a11    = tsb_pkg::ADDR_W'(y1_reg * w_eff + x1_reg);
        req_next.fx     = fx3_reg;
        req_next.fy     = fy3_reg;
    end

    // Valid bits of the address stages and the request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            req_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            req_reg <= req_next;
        end
    end

    // Payload of the address stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= in_data;
            op2_reg   <= item1_reg.opcode;
            near2_reg <= item1_reg.use_nearest;
            idx2_reg  <= item1_reg.texel_index;
            tex2_reg  <= {item1_reg.in_alpha, item1_reg.in_blue,
                          item1_reg.in_green, item1_reg.in_red};
            px2_reg   <= px_next;
            py2_reg   <= py_next;
            op3_reg   <= op2_reg;
            idx3_reg  <= idx2_reg;
            tex3_reg  <= tex2_reg;
            x0_reg    <= x0_next;
            x1_reg    <= x1_next;
            y0_reg    <= y0_next;
            y1_reg    <= y1_next;
            fx3_reg   <= fx_next;
            fy3_reg   <= fy_next;
        end
    end

    assign req = req_reg;

endmodule

/* design/tsb_mem.sv */
// Texel store: two copies, each with one write and two read addresses a cycle.
module tsb_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tsb_pkg::mem_req_t  req,
    output tsb_pkg::filt_req_t fetch
);

    logic [tsb_pkg::TEXEL_W-1:0] bank0_mem [2**tsb_pkg::ADDR_W];
    logic [tsb_pkg::TEXEL_W-1:0] bank1_mem [2**tsb_pkg::ADDR_W];

    logic                          we;
    logic                          loaded_reg;
    logic                          v_reg;
    logic                          zero_reg;
    logic [tsb_pkg::FRAC_BITS-1:0] fx_reg, fy_reg;
    logic [tsb_pkg::TEXEL_W-1:0]   t00_reg, t10_reg, t01_reg, t11_reg;

    assign we = req.valid && (req.opcode == tsb_pkg::OP_WRITE);

    // First copy serves the upper row of the footprint.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                bank0_mem[req.waddr] <= req.wdata;
            end
            t00_reg <= bank0_mem[req.a00];
            t10_reg <= bank0_mem[req.a10];
        end
    end

    // Second copy serves the lower row.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                bank1_mem[req.waddr] <= req.wdata;
            end
            t01_reg <= bank1_mem[req.a01];
            t11_reg <= bank1_mem[req.a11];
        end
    end

    // Loaded flag and sample valid; only samples move on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            v_reg      <= 1'b0;
        end
        else if (en)
        begin
            if (we)
            begin
                loaded_reg <= 1'b1;
            end
            v_reg <= req.valid && (req.opcode == tsb_pkg::OP_SAMPLE);
        end
    end

    // Fractions and the empty-texture flag travel alongside the read data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= !loaded_reg;
            fx_reg   <= req.fx;
            fy_reg   <= req.fy;
        end
    end

    assign fetch.valid = v_reg;
    assign fetch.zero  = zero_reg;
    assign fetch.fx    = fx_reg;
    assign fetch.fy    = fy_reg;
    assign fetch.t00   = t00_reg;
    assign fetch.t10   = t10_reg;
    assign fetch.t01   = t01_reg;
    assign fetch.t11   = t11_reg;

endmodule

/* design/tsb_filter.sv */
// Two blend stages: horizontal, then vertical with rounding to 8 bits.
module tsb_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tsb_pkg::filt_req_t fetch,
    output logic               out_valid,
    output tsb_pkg::out_t      out_data
);

    typedef logic [tsb_pkg::HORZ_W-1:0] horz_t;

    horz_t top_next [tsb_pkg::CHANS];
    horz_t bot_next [tsb_pkg::CHANS];
    horz_t top_reg  [tsb_pkg::CHANS];
    horz_t bot_reg  [tsb_pkg::CHANS];
    logic                          v6_reg;
    logic                          zero6_reg;
    logic [tsb_pkg::FRAC_BITS-1:0] fy6_reg;
    logic [tsb_pkg::COORD_W-1:0]   wx1, wx0, wy1, wy0;
    logic [tsb_pkg::ACC_W-1:0]     acc [tsb_pkg::CHANS];
    logic [tsb_pkg::ACC_W-2*tsb_pkg::FRAC_BITS-1:0] rnd [tsb_pkg::CHANS];
    logic [tsb_pkg::CHANS*tsb_pkg::CHAN_W-1:0] pix_next;
    logic                          v7_reg;
    logic [tsb_pkg::CHANS*tsb_pkg::CHAN_W-1:0] pix_reg;

    // Horizontal blend of each row.
    always_comb
    begin
        wx1 = {1'b0, fetch.fx};
        wx0 = tsb_pkg::ONE_Q - wx1;
        for (int c = 0; c < tsb_pkg::CHANS; c++)
        begin
            top_next[c] = horz_t'(fetch.t00[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] * wx0)
                        + horz_t'(fetch.t10[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] * wx1);
            bot_next[c] = horz_t'(fetch.t01[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] * wx0)
                        + horz_t'(fetch.t11[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] * wx1);
        end
    end

    // Vertical blend, rounding and saturation.
    always_comb
    begin
        wy1 = {1'b0, fy6_reg};
        wy0 = tsb_pkg::ONE_Q - wy1;
        pix_next = '0;
        for (int c = 0; c < tsb_pkg::CHANS; c++)
        begin
            acc[c] = tsb_pkg::ACC_W'(top_reg[c] * wy0) + tsb_pkg::ACC_W'(bot_reg[c] * wy1)
                   + tsb_pkg::ACC_W'(64'd1 << (2*tsb_pkg::FRAC_BITS - 1));
            rnd[c] = acc[c][tsb_pkg::ACC_W-1:2*tsb_pkg::FRAC_BITS];
            if (zero6_reg)
            begin
                pix_next[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] = '0;
            end
            else if (rnd[c] > (tsb_pkg::ACC_W-2*tsb_pkg::FRAC_BITS)'(255))
            begin
                pix_next[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] = '1;
            end
            else
            begin
                pix_next[c*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] = rnd[c][tsb_pkg::CHAN_W-1:0];
            end
        end
    end

    // Valid bits of the blend stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= fetch.valid;
            v7_reg <= v6_reg;
        end
    end

    // Payload of the blend stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            zero6_reg <= fetch.zero;
            fy6_reg   <= fetch.fy;
            pix_reg   <= pix_next;
        end
    end

    assign out_valid          = v7_reg;
    assign out_data.out_red   = pix_reg[0*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W];
    assign out_data.out_green = pix_reg[1*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W];
    assign out_data.out_blue  = pix_reg[2*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W];
    assign out_data.out_alpha = pix_reg[3*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W];

endmodule

/* design/texture_sampler_bilinear_top.sv */
// A sample's result is valid after the input, scaled-position, clamp, address,
// texel store read and blend registers. Throughput: one item per cycle; the whole
// pipeline stalls only while a result waits at the output and out_ready is low.
// Two texel store copies with two read ports each supply the four taps a cycle.
// Reset clears all valid bits and the loaded flag, and sets width and height to 1.
module texture_sampler_bilinear_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tsb_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tsb_pkg::out_t             out_data,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tsb_pkg::DIM_W-1:0] cfg_data
);

    logic                      en;
    logic [tsb_pkg::DIM_W-1:0] tex_width_reg;
    logic [tsb_pkg::DIM_W-1:0] tex_height_reg;
    tsb_pkg::mem_req_t         req;
    tsb_pkg::filt_req_t        fetch;

    // The pipeline moves unless a result waits for its transfer.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= tsb_pkg::DIM_W'(1);
            tex_height_reg <= tsb_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsb_pkg::REG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                tsb_pkg::REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tsb_addr u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .req        (req)
    );

    tsb_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (req),
        .fetch (fetch)
    );

    tsb_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .fetch     (fetch),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the bilinear/nearest texture sampler.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tsb_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tsb_pkg::out_t out_data;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [tsb_pkg::DIM_W-1:0] cfg_data = '0;

    texture_sampler_bilinear_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow copy of the texture state used to predict colors.
    logic [31:0] texels [int];
    logic loaded_seen = 1'b0;
    logic [tsb_pkg::DIM_W-1:0] shadow_width = tsb_pkg::DIM_W'(1);
    logic [tsb_pkg::DIM_W-1:0] shadow_height = tsb_pkg::DIM_W'(1);

    tsb_pkg::in_t pending_items [$];
    tsb_pkg::out_t expected_colors [$];
    int fail_count = 0;
    int mismatch_count = 0;

    function automatic int clip_dim(input logic [tsb_pkg::DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > tsb_pkg::MAX_DIM) return tsb_pkg::MAX_DIM;
        return int'(d);
    endfunction

    function automatic logic [31:0] read_texel(input longint x, input longint y, input longint w);
        int a;
        a = int'((y * w + x) & 64'hFFFF);
        if (texels.exists(a)) return texels[a];
        return 32'h0;
    endfunction

    // Compute the expected color of one sample.
    function automatic tsb_pkg::out_t sample_color(input tsb_pkg::in_t it);
        longint w, h, px, py, x0i, y0i, fx, fy, x0, x1, y0, y1, tp, bt, acc, r;
        logic [31:0] t00, t10, t01, t11;
        logic [7:0] ch [4];
        tsb_pkg::out_t res;
        int c;
        if (!loaded_seen) return '0;
        w = clip_dim(shadow_width);
        h = clip_dim(shadow_height);
        px = longint'(it.coord_u) * (w - 1);
        py = longint'(it.coord_v) * (h - 1);
        if (it.use_nearest)
        begin
            x0 = (px + 32768) >> 16;
            y0 = (py + 32768) >> 16;
            if (x0 > w - 1) x0 = w - 1;
            if (y0 > h - 1) y0 = h - 1;
            t00 = read_texel(x0, y0, w);
            return {t00[7:0], t00[15:8], t00[23:16], t00[31:24]};
        end
        x0i = px >> 16;
        y0i = py >> 16;
        fx = px & 65535;
        fy = py & 65535;
        x0 = (x0i > w - 1) ? w - 1 : x0i;
        x1 = (x0i + 1 > w - 1) ? w - 1 : x0i + 1;
        y0 = (y0i > h - 1) ? h - 1 : y0i;
        y1 = (y0i + 1 > h - 1) ? h - 1 : y0i + 1;
        t00 = read_texel(x0, y0, w);
        t10 = read_texel(x1, y0, w);
        t01 = read_texel(x0, y1, w);
        t11 = read_texel(x1, y1, w);
        for (c = 0; c < 4; c++)
        begin
            tp = longint'(t00[8*c +: 8]) * (65536 - fx) + longint'(t10[8*c +: 8]) * fx;
            bt = longint'(t01[8*c +: 8]) * (65536 - fx) + longint'(t11[8*c +: 8]) * fx;
            acc = tp * (65536 - fy) + bt * fy;
            r = (acc + (64'd1 << 31)) >> 32;
            ch[c] = (r > 255) ? 8'd255 : r[7:0];
        end
        res.out_red = ch[0];
        res.out_green = ch[1];
        res.out_blue = ch[2];
        res.out_alpha = ch[3];
        return res;
    endfunction

    // Input transfer seen at the last rising edge.
    logic in_fire = 1'b0;
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
    end

    // Driver: presents queued items with random gaps, predicting on each transfer.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (in_fire)
        begin
            if (in_data.opcode == tsb_pkg::OP_WRITE)
            begin
                texels[int'(in_data.texel_index)] = {in_data.in_alpha, in_data.in_blue,
                                                     in_data.in_green, in_data.in_red};
                loaded_seen = 1'b1;
            end
            else
            begin
                expected_colors.push_back(sample_color(in_data));
            end
            void'(pending_items.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 1)) send_gap = 0;
        end
        if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_items[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer and throttles the output side.
    int recv_gap = 0;
    always @(posedge clk)
    begin
        tsb_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_colors.size() == 0)
            begin
                fail_count++;
                if (mismatch_count < 10) $display("unexpected result %h", out_data);
                mismatch_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (want !== out_data)
                begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("color mismatch: expected %h got %h", want, out_data);
                    mismatch_count++;
                end
            end
            recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
        end
    end
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic tsb_pkg::in_t make_write(input int idx, input logic [31:0] rgba);
        tsb_pkg::in_t it;
        it = '0;
        it.opcode = tsb_pkg::OP_WRITE;
        it.texel_index = idx[15:0];
        {it.in_alpha, it.in_blue, it.in_green, it.in_red} = rgba;
        it.coord_u = tsb_pkg::COORD_W'($urandom());
        it.coord_v = tsb_pkg::COORD_W'($urandom());
        it.use_nearest = 1'($urandom());
        return it;
    endfunction

    function automatic tsb_pkg::in_t make_sample(input int u, input int v, input logic nearest);
        tsb_pkg::in_t it;
        it = '0;
        it.opcode = tsb_pkg::OP_SAMPLE;
        it.texel_index = tsb_pkg::ADDR_W'($urandom());
        {it.in_alpha, it.in_blue, it.in_green, it.in_red} = $urandom();
        it.coord_u = u[tsb_pkg::COORD_W-1:0];
        it.coord_v = v[tsb_pkg::COORD_W-1:0];
        it.use_nearest = nearest;
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(65537, 131071);
            3: return 32768;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Wait until every expected color has arrived, then let the pipeline drain.
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_colors.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [tsb_pkg::DIM_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tsb_pkg::REG_TEX_WIDTH) shadow_width = val;
        else shadow_height = val;
    endtask

    // Fill the in-use area where it has not been written yet, so that no
    // unwritten texel is ever read.
    task automatic fill_texture();
        int w, h, i;
        w = clip_dim(shadow_width);
        h = clip_dim(shadow_height);
        for (i = 0; i < w * h; i++)
            if (!texels.exists(i))
                pending_items.push_back(make_write(i, $urandom()));
    endtask

    // Stimulus: directed corner cases, then random phases over several sizes.
    initial
    begin
        int sizes [6][2] = '{'{1, 1}, '{2, 2}, '{4, 3}, '{256, 1}, '{1, 256}, '{7, 5}};
        int p, i, j;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Sample before any write returns zeros.
        pending_items.push_back(make_sample(65536, 0, 1'b0));
        pending_items.push_back(make_sample(0, 65536, 1'b1));
        drain();
        // Zero and oversized registers, extreme write fields.
        write_reg(tsb_pkg::REG_TEX_WIDTH, 9'd0);
        write_reg(tsb_pkg::REG_TEX_HEIGHT, 9'd511);
        pending_items.push_back(make_write(65535, 32'hFFFF_FFFF));
        pending_items.push_back(make_write(0, 32'h0000_0000));
        fill_texture();
        drain();
        pending_items.push_back(make_sample(0, 131071, 1'b0));
        pending_items.push_back(make_sample(0, 65536, 1'b1));
        pending_items.push_back(make_sample(0, 32768, 1'b1));
        pending_items.push_back(make_sample(0, 98304, 1'b0));
        pending_items.push_back(make_sample(131071, 0, 1'b0));
        drain();
        write_reg(tsb_pkg::REG_TEX_WIDTH, 9'd256);
        write_reg(tsb_pkg::REG_TEX_HEIGHT, 9'd256);
        for (i = 0; i < 16; i++)
            pending_items.push_back(make_write(65535 - i, $urandom()));
        pending_items.push_back(make_write(0, $urandom()));
        pending_items.push_back(make_write(1, $urandom()));
        pending_items.push_back(make_write(256, $urandom()));
        pending_items.push_back(make_write(257, $urandom()));
        drain();
        pending_items.push_back(make_sample(65536, 65536, 1'b0));
        pending_items.push_back(make_sample(131071, 131071, 1'b1));
        pending_items.push_back(make_sample(0, 0, 1'b0));
        pending_items.push_back(make_sample(128, 128, 1'b1));
        drain();
        // Random phases with different texture sizes.
        for (p = 0; p < 6; p++)
        begin
            write_reg(tsb_pkg::REG_TEX_WIDTH, tsb_pkg::DIM_W'(sizes[p][0]));
            write_reg(tsb_pkg::REG_TEX_HEIGHT, tsb_pkg::DIM_W'(sizes[p][1]));
            fill_texture();
            for (j = 0; j < 90; j++)
            begin
                if ($urandom_range(0, 4) == 0)
                    pending_items.push_back(make_write(
                        $urandom_range(0, clip_dim(shadow_width) * clip_dim(shadow_height) - 1),
                        $urandom()));
                else
                    pending_items.push_back(make_sample(rand_coord(), rand_coord(),
                                                        1'($urandom_range(0, 1))));
            end
            drain();
        end
        if (fail_count == 0 && expected_colors.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

/* sim.f */
design/tsb_pkg.sv
design/tsb_addr.sv
design/tsb_mem.sv
design/tsb_filter.sv
design/texture_sampler_bilinear_top.sv
sim/testbench.sv
